### sv/mer_pkg.sv
// ----------------------------------------------------------------------------
// mer_pkg: shared constants and types of the midpoint ellipse rasterizer
// Field widths, operation codes, multiplier operand selects, register
// indexes and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package mer_pkg;

   localparam int COORD_BITS    = 16;
   localparam int AXIS_BITS     = 11;
   localparam int LEN_BITS      = AXIS_BITS + 1;      // cur_x, cur_y
   localparam int SQ_BITS       = 2 * AXIS_BITS;      // a^2, b^2
   localparam int TERM_BITS     = 3 * AXIS_BITS + 3;  // 2b^2x, 2a^2y
   localparam int DEC_BITS      = 4 * AXIS_BITS - 4;  // decision variable
   localparam int MUL_BITS      = 2 * LEN_BITS + 1;   // widest operand (x^2+x)
   localparam int PROD_BITS     = 2 * MUL_BITS;
   localparam int COLOR_BITS    = 24;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [COLOR_BITS-1:0] COLOR_RESET = {COLOR_BITS{1'b1}};

   // operation codes carried in req_tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIXEL_COLOR = '0;

   // shared multiplier operand selects
   localparam logic [2:0] MUL_AA   = 3'd0;  // a * a
   localparam logic [2:0] MUL_BB   = 3'd1;  // b * b
   localparam logic [2:0] MUL_A2B  = 3'd2;  // a^2 * b
   localparam logic [2:0] MUL_XX   = 3'd3;  // x * x
   localparam logic [2:0] MUL_B2X  = 3'd4;  // b^2 * (x^2 + x)
   localparam logic [2:0] MUL_YY   = 3'd5;  // (y-1) * (y-1)
   localparam logic [2:0] MUL_A2Y  = 3'd6;  // a^2 * (y-1)^2
   localparam logic [2:0] MUL_A2B2 = 3'd7;  // a^2 * b^2

   typedef struct packed {
      logic       load_start;  // capture center and semi-axes
      logic [2:0] mul_sel;
      logic       cap_a2;      // a^2 <= product
      logic       cap_b2;      // b^2 <= product
      logic       init_r1;     // region one start value
      logic       acc_load;    // acc <= product + b^2/4
      logic       acc_add;     // acc <= acc + product
      logic       enter_r2;    // decision <= acc - product, region two
      logic       adv_move;    // step x/y and the 2b^2x, 2a^2y terms
      logic       adv_dec;     // update decision
      logic       emit;        // load output pixel
      logic [1:0] pix_idx;     // mirrored quadrant of the pixel
   } dp_cmd_type;

   typedef struct packed {
      logic lt;       // 2b^2x < 2a^2y
      logic done;     // final point of the curve
      logic region2;  // walking region two
   } dp_status_type;

endpackage

### sv/mer_csr.sv
// ----------------------------------------------------------------------------
// mer_csr: configuration register file
// APB-style access to the pixel color register.
// ----------------------------------------------------------------------------
module mer_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mer_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mer_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready,
   output logic [mer_pkg::COLOR_BITS-1:0]     pixel_color
);

   logic [mer_pkg::COLOR_BITS-1:0]   color_ff, color_in;
   logic [mer_pkg::CSR_IDX_BITS-1:0] reg_idx;
   logic                             wr_en;

   assign reg_idx    = csr_paddr[mer_pkg::CSR_ADDR_BITS-1:2];
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      color_in = color_ff;
      if (wr_en && reg_idx == mer_pkg::CSR_PIXEL_COLOR) begin
         color_in = csr_pwdata[mer_pkg::COLOR_BITS-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_idx == mer_pkg::CSR_PIXEL_COLOR) begin
         csr_prdata = mer_pkg::CSR_DATA_BITS'(color_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= mer_pkg::COLOR_RESET;
      end else begin
         color_ff <= color_in;
      end
   end

   assign pixel_color = color_ff;

endmodule

### sv/mer_datapath.sv
// ----------------------------------------------------------------------------
// mer_datapath: ellipse point state, shared multiplier and pixel output
// Holds the midpoint decision variable and its incremental terms, one
// registered multiplier shared by all setup products, and the output pixel.
// ----------------------------------------------------------------------------
module mer_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mer_pkg::dp_cmd_type                  cmd,
   input  logic signed [mer_pkg::COORD_BITS-1:0] center_x,
   input  logic signed [mer_pkg::COORD_BITS-1:0] center_y,
   input  logic [mer_pkg::AXIS_BITS-1:0]        axis_a,
   input  logic [mer_pkg::AXIS_BITS-1:0]        axis_b,
   input  logic [mer_pkg::COLOR_BITS-1:0]       pixel_color,
   output mer_pkg::dp_status_type               status,
   output logic signed [mer_pkg::COORD_BITS-1:0] pixel_x,
   output logic signed [mer_pkg::COORD_BITS-1:0] pixel_y,
   output logic [mer_pkg::COLOR_BITS-1:0]       color_out
);

   localparam int CB = mer_pkg::COORD_BITS;
   localparam int LB = mer_pkg::LEN_BITS;
   localparam int SB = mer_pkg::SQ_BITS;
   localparam int TB = mer_pkg::TERM_BITS;
   localparam int DB = mer_pkg::DEC_BITS;
   localparam int MB = mer_pkg::MUL_BITS;
   localparam int PB = mer_pkg::PROD_BITS;

   logic [CB-1:0] center_col_ff, center_col_in, center_row_ff, center_row_in;
   logic [mer_pkg::AXIS_BITS-1:0] a_len_ff, a_len_in, b_len_ff, b_len_in;
   logic [LB-1:0] x_ff, x_in, y_ff, y_in;
   logic [SB-1:0] a2_ff, a2_in, b2_ff, b2_in;
   logic [TB-1:0] t2bx_ff, t2bx_in, t2ay_ff, t2ay_in;
   logic [DB-1:0] dec_ff, dec_in, acc_ff, acc_in;
   logic          region2_ff, region2_in, move_ff, move_in;
   logic [PB-1:0] prod_ff, prod_in;
   logic [CB-1:0] pix_x_ff, pix_x_in, pix_y_ff, pix_y_in;
   logic [mer_pkg::COLOR_BITS-1:0] color_ff, color_in;

   logic [MB-1:0] mul_l, mul_r;
   logic [LB-1:0] ym1;
   logic [TB-1:0] two_a2, two_b2;
   logic [DB-1:0] prod_dec, bx_term, ay_term, sq_term;
   logic          dec_neg, dec_zero;
   logic [CB-1:0] dx_pos, dx_neg, dy_pos, dy_neg;

   // |y-1|; squares the same as the wrapped value when y is zero
   assign ym1      = (y_ff == '0) ? LB'(1) : y_ff - LB'(1);
   assign two_a2   = TB'({a2_ff, 1'b0});
   assign two_b2   = TB'({b2_ff, 1'b0});
   assign prod_dec = prod_ff[DB-1:0];
   assign dec_neg  = dec_ff[DB-1];
   assign dec_zero = (dec_ff == '0);

   always_comb begin
      mul_l = '0;
      mul_r = '0;
      unique case (cmd.mul_sel)
         mer_pkg::MUL_AA: begin
            mul_l = MB'(a_len_ff);
            mul_r = MB'(a_len_ff);
         end
         mer_pkg::MUL_BB: begin
            mul_l = MB'(b_len_ff);
            mul_r = MB'(b_len_ff);
         end
         mer_pkg::MUL_A2B: begin
            mul_l = MB'(a2_ff);
            mul_r = MB'(b_len_ff);
         end
         mer_pkg::MUL_XX: begin
            mul_l = MB'(x_ff);
            mul_r = MB'(x_ff);
         end
         mer_pkg::MUL_B2X: begin
            mul_l = MB'(b2_ff);
            mul_r = prod_ff[MB-1:0] + MB'(x_ff);
         end
         mer_pkg::MUL_YY: begin
            mul_l = MB'(ym1);
            mul_r = MB'(ym1);
         end
         mer_pkg::MUL_A2Y: begin
            mul_l = MB'(a2_ff);
            mul_r = prod_ff[MB-1:0];
         end
         mer_pkg::MUL_A2B2: begin
            mul_l = MB'(a2_ff);
            mul_r = MB'(b2_ff);
         end
         default: begin
            mul_l = '0;
            mul_r = '0;
         end
      endcase
   end

   assign prod_in = PB'(mul_l) * PB'(mul_r);

   // terms of the decision update; region one subtracts 2a^2y only on a y step,
   // region two adds 2b^2x only on an x step
   always_comb begin
      if (region2_ff) begin
         bx_term = move_ff ? DB'(t2bx_ff) : '0;
         ay_term = DB'(t2ay_ff);
         sq_term = DB'(a2_ff);
      end else begin
         bx_term = DB'(t2bx_ff);
         ay_term = move_ff ? DB'(t2ay_ff) : '0;
         sq_term = DB'(b2_ff);
      end
   end

   assign dx_pos = CB'(x_ff);
   assign dx_neg = -dx_pos;
   assign dy_pos = CB'(y_ff);
   assign dy_neg = -dy_pos;

   always_comb begin
      center_col_in = center_col_ff;
      center_row_in = center_row_ff;
      a_len_in      = a_len_ff;
      b_len_in      = b_len_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      a2_in         = a2_ff;
      b2_in         = b2_ff;
      t2bx_in       = t2bx_ff;
      t2ay_in       = t2ay_ff;
      dec_in        = dec_ff;
      acc_in        = acc_ff;
      region2_in    = region2_ff;
      move_in       = move_ff;
      pix_x_in      = pix_x_ff;
      pix_y_in      = pix_y_ff;
      color_in      = color_ff;

      if (cmd.load_start) begin
         center_col_in = center_x;
         center_row_in = center_y;
         a_len_in      = axis_a;
         b_len_in      = axis_b;
         x_in          = '0;
         y_in          = LB'(axis_b);
         t2bx_in       = '0;
         region2_in    = 1'b0;
      end
      if (cmd.cap_a2) begin
         a2_in = prod_ff[SB-1:0];
      end
      if (cmd.cap_b2) begin
         b2_in = prod_ff[SB-1:0];
      end
      if (cmd.init_r1) begin
         t2ay_in = {prod_ff[TB-2:0], 1'b0};
         dec_in  = DB'(b2_ff) - prod_dec + DB'(a2_ff >> 2);
      end
      if (cmd.acc_load) begin
         acc_in = prod_dec + DB'(b2_ff >> 2);
      end
      if (cmd.acc_add) begin
         acc_in = acc_ff + prod_dec;
      end
      if (cmd.enter_r2) begin
         dec_in     = acc_ff - prod_dec;
         region2_in = 1'b1;
      end
      if (cmd.adv_move) begin
         if (region2_ff) begin
            move_in = dec_neg || dec_zero;
            y_in    = y_ff - LB'(1);
            t2ay_in = t2ay_ff - two_a2;
            if (dec_neg || dec_zero) begin
               x_in    = x_ff + LB'(1);
               t2bx_in = t2bx_ff + two_b2;
            end
         end else begin
            move_in = !dec_neg;
            x_in    = x_ff + LB'(1);
            t2bx_in = t2bx_ff + two_b2;
            if (!dec_neg) begin
               y_in    = y_ff - LB'(1);
               t2ay_in = t2ay_ff - two_a2;
            end
         end
      end
      if (cmd.adv_dec) begin
         dec_in = dec_ff + bx_term - ay_term + sq_term;
      end
      if (cmd.emit) begin
         color_in = pixel_color;
         unique case (cmd.pix_idx)
            2'd0: begin
               pix_x_in = center_col_ff + dx_pos;
               pix_y_in = center_row_ff + dy_pos;
            end
            2'd1: begin
               pix_x_in = center_col_ff + dx_pos;
               pix_y_in = center_row_ff + dy_neg;
            end
            2'd2: begin
               pix_x_in = center_col_ff + dx_neg;
               pix_y_in = center_row_ff + dy_neg;
            end
            default: begin
               pix_x_in = center_col_ff + dx_neg;
               pix_y_in = center_row_ff + dy_pos;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region2_ff <= 1'b0;
         move_ff    <= 1'b0;
      end else begin
         region2_ff <= region2_in;
         move_ff    <= move_in;
      end
   end

   always_ff @(posedge clock) begin
      center_col_ff <= center_col_in;
      center_row_ff <= center_row_in;
      a_len_ff      <= a_len_in;
      b_len_ff      <= b_len_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      a2_ff         <= a2_in;
      b2_ff         <= b2_in;
      t2bx_ff       <= t2bx_in;
      t2ay_ff       <= t2ay_in;
      dec_ff        <= dec_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      pix_x_ff      <= pix_x_in;
      pix_y_ff      <= pix_y_in;
      color_ff      <= color_in;
   end

   assign status.lt      = (t2bx_ff < t2ay_ff);
   assign status.done    = region2_ff && (y_ff == '0);
   assign status.region2 = region2_ff;

   assign pixel_x   = pix_x_ff;
   assign pixel_y   = pix_y_ff;
   assign color_out = color_ff;

endmodule

### sv/mer_ctrl.sv
// ----------------------------------------------------------------------------
// mer_ctrl: rasterizer sequencer
// Accepts transactions, sequences setup products, emits the four mirrored
// pixels of a point and runs the advance (ADV1, ADV2).
// ----------------------------------------------------------------------------
module mer_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tuser,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic                   rsp_tlast,
   output logic                   rsp_tuser,
   input  mer_pkg::dp_status_type status,
   output mer_pkg::dp_cmd_type    cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_M1   = 4'd1;   // a*a
   localparam logic [3:0] S_M2   = 4'd2;   // b*b, keep a^2
   localparam logic [3:0] S_M3   = 4'd3;   // a^2*b, keep b^2
   localparam logic [3:0] S_M4   = 4'd4;   // region one start value
   localparam logic [3:0] S_CHK  = 4'd5;   // region test after start
   localparam logic [3:0] S_E1   = 4'd6;   // x*x
   localparam logic [3:0] S_E2   = 4'd7;   // b^2*(x^2+x)
   localparam logic [3:0] S_E3   = 4'd8;   // acc load, (y-1)^2
   localparam logic [3:0] S_E4   = 4'd9;   // a^2*(y-1)^2
   localparam logic [3:0] S_E5   = 4'd10;  // acc add, a^2*b^2
   localparam logic [3:0] S_E6   = 4'd11;  // region two start value
   localparam logic [3:0] S_EMIT = 4'd12;
   localparam logic [3:0] S_ADV1 = 4'd13;
   localparam logic [3:0] S_ADV2 = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [1:0] pix_ff, pix_in;
   logic       active_ff, active_in;
   logic       valid_ff, valid_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       req_fire, out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !valid_ff || rsp_tready;

   always_comb begin
      state_in  = state_ff;
      pix_in    = pix_ff;
      active_in = active_ff;
      valid_in  = rsp_tready ? 1'b0 : valid_ff;
      last_in   = last_ff;
      done_in   = done_ff;
      cmd       = '0;
      cmd.mul_sel = mer_pkg::MUL_AA;
      cmd.pix_idx = pix_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == mer_pkg::OP_START) begin
                  cmd.load_start = 1'b1;
                  active_in      = 1'b1;
                  state_in       = S_M1;
               end else if (active_ff) begin
                  pix_in   = 2'd0;
                  state_in = S_EMIT;
               end
            end
         end
         S_M1: begin
            cmd.mul_sel = mer_pkg::MUL_AA;
            state_in    = S_M2;
         end
         S_M2: begin
            cmd.mul_sel = mer_pkg::MUL_BB;
            cmd.cap_a2  = 1'b1;
            state_in    = S_M3;
         end
         S_M3: begin
            cmd.mul_sel = mer_pkg::MUL_A2B;
            cmd.cap_b2  = 1'b1;
            state_in    = S_M4;
         end
         S_M4: begin
            cmd.init_r1 = 1'b1;
            state_in    = S_CHK;
         end
         S_CHK: begin
            state_in = status.lt ? S_IDLE : S_E1;
         end
         S_E1: begin
            cmd.mul_sel = mer_pkg::MUL_XX;
            state_in    = S_E2;
         end
         S_E2: begin
            cmd.mul_sel = mer_pkg::MUL_B2X;
            state_in    = S_E3;
         end
         S_E3: begin
            cmd.acc_load = 1'b1;
            cmd.mul_sel  = mer_pkg::MUL_YY;
            state_in     = S_E4;
         end
         S_E4: begin
            cmd.mul_sel = mer_pkg::MUL_A2Y;
            state_in    = S_E5;
         end
         S_E5: begin
            cmd.acc_add = 1'b1;
            cmd.mul_sel = mer_pkg::MUL_A2B2;
            state_in    = S_E6;
         end
         S_E6: begin
            cmd.enter_r2 = 1'b1;
            state_in     = S_IDLE;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               last_in  = (pix_ff == 2'd3);
               done_in  = (pix_ff == 2'd3) && status.done;
               pix_in   = pix_ff + 2'd1;
               if (pix_ff == 2'd3) begin
                  if (status.done) begin
                     active_in = 1'b0;
                     state_in  = S_IDLE;
                  end else begin
                     state_in = S_ADV1;
                  end
               end
            end
         end
         S_ADV1: begin
            cmd.adv_move = 1'b1;
            state_in     = S_ADV2;
         end
         S_ADV2: begin
            cmd.adv_dec = 1'b1;
            // terms were moved in ADV1; region one hands over to region two
            // once 2b^2x has caught up with 2a^2y
            state_in = S_IDLE;
            if (!status.region2 && !status.lt) begin
               state_in = S_E1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         pix_ff    <= 2'd0;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pix_ff    <= pix_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      done_ff <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = done_ff;

endmodule

### sv/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer: axis-aligned two-region midpoint ellipse
// A start transaction loads center and semi-axes; each step transaction
// produces the four quadrant-mirrored pixels of the current point.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  req_*     in   req_tvalid/req_tready  tdata: center_x, center_y, axis_a,
//                                        axis_b; tuser: operation
//  rsp_*     out  rsp_tvalid/rsp_tready  tdata: pixel_x, pixel_y, color_out;
//                                        tlast: last_of_point; tuser: curve_done
//  csr_*     in   APB, pready always 1   reg 0 (addr 0): pixel_color
//
//  Start: accept, the setup products on the shared multiplier (M1 to M4)
//  and the region test (CHK), plus region two setup (E1 to E6) when a or
//  b is zero. Step: accept, the four pixels (EMIT) and the advance (ADV1,
//  ADV2); the final point skips the advance, and region two setup follows
//  on the point where region two is entered. One transaction is worked on
//  at a time; rsp backpressure stalls only the pixel cycles. Synchronous
//  active-high reset, color resets to white.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [15:0] center_x, [31:16] center_y, [42:32] axis_a, [53:43] axis_b
   input  logic [55:0]                        req_tdata,
   // [0] operation
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [15:0] pixel_x, [31:16] pixel_y, [55:32] color_out
   output logic [55:0]                        rsp_tdata,
   output logic                               rsp_tlast,
   // [0] curve_done
   output logic                               rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mer_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [mer_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [mer_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);

   localparam int CB = mer_pkg::COORD_BITS;
   localparam int AB = mer_pkg::AXIS_BITS;

   mer_pkg::dp_cmd_type            cmd;
   mer_pkg::dp_status_type         status;
   logic [mer_pkg::COLOR_BITS-1:0] pixel_color;
   logic signed [CB-1:0]           pixel_x, pixel_y;
   logic [mer_pkg::COLOR_BITS-1:0] color_out;

   mer_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pixel_color (pixel_color)
   );

   mer_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tuser  (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   // field slices of the request word
   mer_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .center_x    (req_tdata[CB-1:0]),
      .center_y    (req_tdata[2*CB-1:CB]),
      .axis_a      (req_tdata[2*CB+AB-1:2*CB]),
      .axis_b      (req_tdata[2*CB+2*AB-1:2*CB+AB]),
      .pixel_color (pixel_color),
      .status      (status),
      .pixel_x     (pixel_x),
      .pixel_y     (pixel_y),
      .color_out   (color_out)
   );

   assign rsp_tdata = {color_out, pixel_y, pixel_x};

endmodule

### verif/midpoint_ellipse_rasterizer_tb.sv
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer_tb: self-checking bench for the ellipse rasterizer
// A short directed sweep followed by random start/step sequences. The
// sequences run over four traffic phases, with a different pixel color in
// each phase. Each pixel is checked field by field against a typed row's
// expectation or an in-bench model of the two-region midpoint algorithm.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import mer_pkg::*;

   // ------------------------------------------------------------------------
   // bench constants
   // ------------------------------------------------------------------------
   localparam int CLK_HALF      = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int SETTLE_CYCLES = 20;    // room for the longest start or step
   localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
   localparam int PHASE_ITEMS   = 76;
   localparam int MAX_REPORTS   = 40;
   localparam int STEP_CAP      = 40;    // keeps wide ellipses short
   localparam int N_DIRECTED    = 27;

   localparam logic [63:0] DEC_MASK = (64'd1 << DEC_BITS) - 64'd1;
   localparam logic [CSR_ADDR_BITS-1:0] COLOR_ADDR = CSR_ADDR_BITS'(4 * CSR_PIXEL_COLOR);

   // one emitted pixel, as the rsp channel carries it
   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [COLOR_BITS-1:0] color;
      logic                  last;
      logic                  done;
   } pixel_type;

   // one row of the directed sweep; typed rows carry their own expectation:
   // n_pix pixels all at (tx,ty), white, last and done on the fourth
   typedef struct packed {
      logic                  op;
      logic [COORD_BITS-1:0] cx;
      logic [COORD_BITS-1:0] cy;
      logic [AXIS_BITS-1:0]  a;
      logic [AXIS_BITS-1:0]  b;
      logic                  typed;
      logic [2:0]            n_pix;
      logic [COORD_BITS-1:0] tx;
      logic [COORD_BITS-1:0] ty;
   } sweep_row_type;

   localparam sweep_row_type SWEEP_ROWS [N_DIRECTED] = '{
      // step straight after reset: idle, nothing comes out
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b1, 3'd0, 16'h0000, 16'h0000},
      // degenerate ellipse, both semi-axes zero: one point at the center
      '{OP_START, 16'h0000, 16'h0000, 11'd0,    11'd0,    1'b1, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b1, 3'd4, 16'h0000, 16'h0000},
      // step after the final point: idle again
      '{OP_STEP,  16'hFFFF, 16'hFFFF, 11'h7FF,  11'h7FF,  1'b1, 3'd0, 16'h0000, 16'h0000},
      // zero b with widest a at the corner center: single point
      '{OP_START, 16'h7FFF, 16'h8000, 11'd2047, 11'd0,    1'b1, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b1, 3'd4, 16'h7FFF, 16'h8000},
      // zero a: vertical line, then one idle step
      '{OP_START, 16'h8000, 16'h7FFF, 11'd0,    11'd2,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'hFFFF, 16'hFFFF, 11'h7FF,  11'h7FF,  1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'hFFFF, 16'hFFFF, 11'h7FF,  11'h7FF,  1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      // small full ellipse, crosses into region two
      '{OP_START, 16'h0064, 16'hFF9C, 11'd3,    11'd2,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      // widest axes at the max corner: coordinates wrap
      '{OP_START, 16'h7FFF, 16'h7FFF, 11'd2047, 11'd2047, 1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      // start while active abandons the big one; unit circle follows
      '{OP_START, 16'hFFFF, 16'hFFFF, 11'd1,    11'd1,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000},
      '{OP_STEP,  16'h0000, 16'h0000, 11'd0,    11'd0,    1'b0, 3'd0, 16'h0000, 16'h0000}
   };

   // ------------------------------------------------------------------------
   // DUT signals, all known from time zero
   // ------------------------------------------------------------------------
   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [55:0]              req_tdata   = '0;
   logic                     req_tuser   = OP_STEP;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b1;
   logic [55:0]              rsp_tdata;
   logic                     rsp_tlast;
   logic                     rsp_tuser;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   always #CLK_HALF clock = ~clock;

   midpoint_ellipse_rasterizer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // [15:0] cx, [31:16] cy, [42:32] a, [53:43] b
      .req_tuser   (req_tuser),    // [0] operation
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // [15:0] x, [31:16] y, [55:32] color
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),    // [0] curve_done
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // ------------------------------------------------------------------------
   // bench state
   // ------------------------------------------------------------------------
   pixel_type pending_pixels[$];  // expected pixels, oldest first
   int        mismatch_count = 0;
   int        idle_pct       = 0; // sender idle chance per cycle
   int        stall_pct      = 0; // receiver stall chance per cycle
   int        quiet_cycles   = 0;

   // rasterizer model state; 64-bit like the algorithm's own arithmetic,
   // decision masked to DEC_BITS two's complement
   logic                  curve_active  = 1'b0;
   logic                  in_region_two = 1'b0;
   logic [COORD_BITS-1:0] center_col    = '0;
   logic [COORD_BITS-1:0] center_row    = '0;
   logic [63:0]           off_x         = '0;
   logic [63:0]           off_y         = '0;
   logic [63:0]           a_sq          = '0;
   logic [63:0]           b_sq          = '0;
   logic [63:0]           b2x_term      = '0;  // 2 b^2 x
   logic [63:0]           a2y_term      = '0;  // 2 a^2 y
   logic [63:0]           decision      = '0;
   logic [COLOR_BITS-1:0] pixel_color   = COLOR_RESET;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // append one expected pixel at the young end of the queue
   function automatic void queue_pixel(input pixel_type pix);
      pending_pixels = {pending_pixels, pix};
   endfunction

   // ------------------------------------------------------------------------
   // midpoint ellipse model
   // ------------------------------------------------------------------------
   // region two seed: b^2(x^2+x) + b^2/4 + a^2(y-1)^2 - a^2 b^2
   function automatic void seed_region_two();
      logic [63:0] ym1;
      ym1 = off_y - 64'd1;
      decision = (b_sq * (off_x * off_x + off_x) + b_sq / 64'd4
                  + a_sq * (ym1 * ym1) - a_sq * b_sq) & DEC_MASK;
      in_region_two = 1'b1;
   endfunction

   function automatic void load_ellipse(input logic [55:0] data);
      logic [63:0] a_len, b_len;
      a_len         = 64'(data[42:32]);
      b_len         = 64'(data[53:43]);
      center_col    = data[15:0];
      center_row    = data[31:16];
      a_sq          = a_len * a_len;
      b_sq          = b_len * b_len;
      off_x         = '0;
      off_y         = b_len;
      b2x_term      = '0;
      a2y_term      = 64'd2 * a_sq * b_len;
      in_region_two = 1'b0;
      curve_active  = 1'b1;
      decision      = (b_sq - a_sq * b_len + a_sq / 64'd4) & DEC_MASK;
      // zero a or zero b skips region one altogether
      if (!(b2x_term < a2y_term))
         seed_region_two();
   endfunction

   function automatic void advance_point();
      if (!in_region_two) begin
         off_x    = off_x + 64'd1;
         b2x_term = b2x_term + 64'd2 * b_sq;
         if (decision[DEC_BITS-1]) begin
            decision = (decision + b2x_term + b_sq) & DEC_MASK;
         end else begin
            off_y    = off_y - 64'd1;
            a2y_term = a2y_term - 64'd2 * a_sq;
            decision = (decision + b2x_term - a2y_term + b_sq) & DEC_MASK;
         end
         if (!(b2x_term < a2y_term))
            seed_region_two();
      end else begin
         off_y    = off_y - 64'd1;
         a2y_term = a2y_term - 64'd2 * a_sq;
         if (!decision[DEC_BITS-1] && decision != 64'd0) begin
            decision = (decision + a_sq - a2y_term) & DEC_MASK;
         end else begin
            off_x    = off_x + 64'd1;
            b2x_term = b2x_term + 64'd2 * b_sq;
            decision = (decision + b2x_term - a2y_term + a_sq) & DEC_MASK;
         end
      end
   endfunction

   // applies one accepted request; returns the number of pixels it yields and
   // queues them when keep is set
   function automatic int rasterize(input logic op, input logic [55:0] data,
                                    input bit keep);
      logic [COORD_BITS-1:0] dx, dy;
      logic                  final_point;
      pixel_type             pix;
      if (op == OP_START) begin
         load_ellipse(data);
         return 0;
      end
      if (!curve_active)
         return 0;
      dx          = off_x[COORD_BITS-1:0];
      dy          = off_y[COORD_BITS-1:0];
      final_point = in_region_two && off_y == 64'd0;
      // quadrant order: (+x,+y) (+x,-y) (-x,-y) (-x,+y)
      for (int k = 0; k < 4; k++) begin
         pix.x     = (k < 2) ? center_col + dx : center_col - dx;
         pix.y     = (k == 0 || k == 3) ? center_row + dy : center_row - dy;
         pix.color = pixel_color;
         pix.last  = (k == 3);
         pix.done  = (k == 3) && final_point;
         if (keep)
            queue_pixel(pix);
      end
      if (final_point)
         curve_active = 1'b0;
      else
         advance_point();
      return 4;
   endfunction

   // ------------------------------------------------------------------------
   // request driver; callers stand at a rising edge
   // ------------------------------------------------------------------------
   task automatic send_request(input logic op, input logic [55:0] data, input bit keep,
                               output int n_pix);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      // model runs on the accepting edge, before any of its pixels can show
      n_pix = rasterize(op, data, keep);
   endtask

   task automatic sender_gap();
      int n;
      n = 0;
      while ($urandom_range(99) < idle_pct)
         n++;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // stop sending, wait for every expected pixel, then let the block settle
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // APB register access: write, then read back
   // ------------------------------------------------------------------------
   task automatic write_color(input logic [CSR_DATA_BITS-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= COLOR_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pixel_color = value[COLOR_BITS-1:0];
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[COLOR_BITS-1:0] != pixel_color)
         report_mismatch("pixel_color readback", 64'(csr_prdata), 64'(pixel_color));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // random stimulus
   // ------------------------------------------------------------------------
   function automatic logic [55:0] noise_payload();
      logic [55:0] v;
      v = 56'({$urandom, $urandom});
      v[55:54] = 2'b00;
      return v;
   endfunction

   // mostly complete curves with random centers and axes; some curves are
   // cut short by the next start, some are followed by idle steps
   task automatic random_curves(input int quota);
      int                   sent, steps, cap, n, pick;
      logic [AXIS_BITS-1:0] a, b;
      sent = 0;
      while (sent < quota) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            a = AXIS_BITS'($urandom_range(0, 12));
            b = AXIS_BITS'($urandom_range(0, 12));
         end else if (pick < 90) begin
            a = AXIS_BITS'($urandom_range(0, 80));
            b = AXIS_BITS'($urandom_range(0, 80));
         end else begin
            a = AXIS_BITS'($urandom_range(0, 2047));
            b = AXIS_BITS'($urandom_range(0, 2047));
         end
         send_request(OP_START, {2'b00, b, a, 16'($urandom), 16'($urandom)}, 1'b1, n);
         sent++;
         sender_gap();
         cap = ($urandom_range(99) < 15) ? $urandom_range(0, 4) : STEP_CAP;
         steps = 0;
         while (curve_active && steps < cap && sent < quota) begin
            send_request(OP_STEP, noise_payload(), 1'b1, n);
            sent++;
            steps++;
            sender_gap();
         end
         if ($urandom_range(99) < 20) begin
            repeat ($urandom_range(1, 3)) begin
               send_request(OP_STEP, noise_payload(), 1'b1, n);
               sent++;
               sender_gap();
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // receiver backpressure
   // ------------------------------------------------------------------------
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   // ------------------------------------------------------------------------
   // pixel checker and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            report_mismatch("unexpected pixel transaction", 64'(rsp_tdata), '0);
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_tdata[15:0] != want.x)
               report_mismatch("pixel_x", 64'(rsp_tdata[15:0]), 64'(want.x));
            if (rsp_tdata[31:16] != want.y)
               report_mismatch("pixel_y", 64'(rsp_tdata[31:16]), 64'(want.y));
            if (rsp_tdata[55:32] != want.color)
               report_mismatch("color_out", 64'(rsp_tdata[55:32]), 64'(want.color));
            if (rsp_tlast != want.last)
               report_mismatch("last_of_point", 64'(rsp_tlast), 64'(want.last));
            if (rsp_tuser != want.done)
               report_mismatch("curve_done", 64'(rsp_tuser), 64'(want.done));
         end
      end
      // any transaction on any port restarts the count
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      sweep_row_type              row;
      pixel_type                  typed_pix;
      int                         n;
      int                         phase_idle  [4] = '{0, 48, 0, 23};
      int                         phase_stall [4] = '{0, 0, 48, 23};
      logic [CSR_DATA_BITS-1:0]   phase_color [4];

      // black, white with junk in the unused top byte, then two random
      phase_color[0] = '0;
      phase_color[1] = '1;
      phase_color[2] = $urandom;
      phase_color[3] = $urandom;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed sweep under reset color, no idling
      for (int i = 0; i < N_DIRECTED; i++) begin
         row = SWEEP_ROWS[i];
         send_request(row.op, {2'b00, row.b, row.a, row.cy, row.cx}, !row.typed, n);
         if (row.typed) begin
            for (int k = 0; k < row.n_pix; k++) begin
               typed_pix.x     = row.tx;
               typed_pix.y     = row.ty;
               typed_pix.color = COLOR_RESET;
               typed_pix.last  = (k == 3);
               typed_pix.done  = (k == 3);
               queue_pixel(typed_pix);
            end
         end
      end
      drain_pixels();

      // random phases; color is only rewritten with the block drained
      for (int p = 0; p < 4; p++) begin
         write_color(phase_color[p]);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         random_curves(PHASE_ITEMS);
         drain_pixels();
      end

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
